FILE: rtl/ccfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccfb_pkg: shared types and constants of the COBS/CRC frame builder
// Holds the opcode codes, the block command passed from the front end to
// the back end, the CRC helpers and the default sizes.
// ----------------------------------------------------------------------------
package ccfb_pkg;

	// Input opcodes.
	localparam logic OP_HEADER  = 1'b0;
	localparam logic OP_PAYLOAD = 1'b1;

	// Largest payload a header may announce; longer frames are dropped.
	localparam logic [7:0] MAX_PAYLOAD = 8'd32;

	// Default depth of the run byte buffer.
	localparam int RUN_DEPTH_DEF = 64;

	// Longest block COBS allows.
	localparam int MAX_BLOCK = 254;

	// Depth of the command queue between front and back end.
	localparam int CMDQ_DEPTH = 4;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [7:0]  DELIM    = 8'h00;

	// One unit of work for the back end: either a block (code byte plus
	// count buffered bytes) or the frame delimiter.
	typedef struct packed {
		logic       is_delim;
		logic       last;
		logic [7:0] count;
	} cmd_t;

	// CRC-16/CCITT-FALSE update by one byte, MSB first.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: rtl/ccfb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccfb_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds its
// value while no read is issued.
// ----------------------------------------------------------------------------
module ccfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/ccfb_cmdq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccfb_cmdq: command queue between front and back end
// A small register FIFO of block and delimiter commands.
// ----------------------------------------------------------------------------
module ccfb_cmdq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ccfb_pkg::cmd_t  push_cmd,
	output logic            not_full,
	input  logic            pop,
	output logic            not_empty,
	output ccfb_pkg::cmd_t  head_cmd
);

	localparam int PW = $clog2(ccfb_pkg::CMDQ_DEPTH);
	localparam int CW = $clog2(ccfb_pkg::CMDQ_DEPTH + 1);

	ccfb_pkg::cmd_t entry_q [ccfb_pkg::CMDQ_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign not_full  = (count_q != CW'(ccfb_pkg::CMDQ_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign head_cmd  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(ccfb_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(ccfb_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/ccfb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccfb_front: input side of the frame builder
// Accepts words, tracks the open frame, walks the body one byte per cycle
// when not stalled by a full queue or run buffer, keeps the CRC, buffers
// nonzero bytes and queues a block command per zero byte and at frame end.
// ----------------------------------------------------------------------------
module ccfb_front #(
	parameter int RUN_DEPTH = ccfb_pkg::RUN_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         opcode,
	input  logic [31:0]                  msg_id,
	input  logic [7:0]                   msg_len,
	input  logic [7:0]                   data_byte,
	output logic                         ram_wr_en,
	output logic [$clog2(RUN_DEPTH)-1:0] ram_wr_addr,
	output logic [7:0]                   ram_wr_data,
	input  logic                         slot_release,
	output logic                         cmd_push,
	output ccfb_pkg::cmd_t               cmd_out,
	input  logic                         cmd_not_full
);

	localparam int PW = $clog2(RUN_DEPTH);
	localparam int OW = $clog2(RUN_DEPTH + 1);
	localparam logic [7:0] RUN_CAP =
		8'((RUN_DEPTH < ccfb_pkg::MAX_BLOCK) ? RUN_DEPTH : ccfb_pkg::MAX_BLOCK);

	typedef enum logic [2:0] {
		F_IDLE, F_HDR, F_PAY, F_CRC0, F_CRC1, F_FIN, F_DELIM
	} fstate_t;

	fstate_t        state_q;
	logic           frame_open_q;
	logic [7:0]     bytes_rem_q;
	logic [15:0]    crc_q;
	logic [7:0]     run_cnt_q;
	logic [OW-1:0]  occ_q;
	logic [PW-1:0]  wr_ptr_q;
	logic [2:0]     idx_q;
	logic [31:0]    id_q;
	logic [7:0]     len_q;
	logic [7:0]     data_q;

	logic [7:0]     cur_byte;
	logic           body_active;
	logic           is_zero;
	logic           need_push;
	logic           need_write;
	logic           go;
	logic [7:0]     rem_after;
	logic           finishing;
	logic           blk_last;
	logic           accept;

	assign in_ready = (state_q == F_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cur_byte = 8'h00;
		case (state_q)
			F_HDR: begin
				case (idx_q)
					3'd0:    cur_byte = id_q[7:0];
					3'd1:    cur_byte = id_q[15:8];
					3'd2:    cur_byte = id_q[23:16];
					3'd3:    cur_byte = id_q[31:24];
					3'd4:    cur_byte = len_q;
					default: cur_byte = 8'h00;
				endcase
			end
			F_PAY:   cur_byte = data_q;
			F_CRC0:  cur_byte = crc_q[7:0];
			F_CRC1:  cur_byte = crc_q[15:8];
			default: cur_byte = 8'h00;
		endcase
	end

	assign body_active = (state_q == F_HDR) || (state_q == F_PAY) ||
	                     (state_q == F_CRC0) || (state_q == F_CRC1);
	assign is_zero     = (cur_byte == 8'h00);
	assign rem_after   = (bytes_rem_q != 8'd0) ? bytes_rem_q - 8'd1 : 8'd0;
	assign finishing   = (rem_after == 8'd0);

	// Bytes beyond the run capacity are left out of the encoded stream.
	assign need_write = body_active && !is_zero && (run_cnt_q < RUN_CAP);
	assign need_push  = (body_active && is_zero) || (state_q == F_FIN) ||
	                    (state_q == F_DELIM);
	assign go = (!need_push || cmd_not_full) &&
	            (!need_write || (occ_q != OW'(RUN_DEPTH)));

	// Only the high length byte ends the header's output, and only if a payload
	// follows; zero bytes inside the id close blocks followed by more bytes.
	always_comb begin
		case (state_q)
			F_HDR:   blk_last = (idx_q == 3'd5) && (len_q != 8'd0);
			F_PAY:   blk_last = !finishing;
			default: blk_last = 1'b0;
		endcase
	end

	always_comb begin
		cmd_out.is_delim = (state_q == F_DELIM);
		cmd_out.last     = (state_q == F_DELIM) ? 1'b1 : blk_last;
		cmd_out.count    = (state_q == F_DELIM) ? 8'd0 : run_cnt_q;
	end

	assign cmd_push    = need_push && go;
	assign ram_wr_en   = need_write && go;
	assign ram_wr_addr = wr_ptr_q;
	assign ram_wr_data = cur_byte;

	// Latched word fields.
	always_ff @(posedge clk) begin
		if (accept) begin
			id_q   <= msg_id;
			len_q  <= msg_len;
			data_q <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= F_IDLE;
			frame_open_q <= 1'b0;
			bytes_rem_q  <= 8'd0;
			crc_q        <= ccfb_pkg::CRC_INIT;
			run_cnt_q    <= 8'd0;
			occ_q        <= '0;
			wr_ptr_q     <= '0;
			idx_q        <= 3'd0;
		end else begin
			occ_q <= occ_q + OW'(ram_wr_en) - OW'(slot_release);
			if (ram_wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(RUN_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (body_active && go) begin
				if (is_zero) begin
					run_cnt_q <= 8'd0;
				end else if (need_write) begin
					run_cnt_q <= run_cnt_q + 8'd1;
				end
			end
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						if (opcode == ccfb_pkg::OP_HEADER) begin
							if (!frame_open_q && (msg_len <= ccfb_pkg::MAX_PAYLOAD)) begin
								frame_open_q <= 1'b1;
								bytes_rem_q  <= msg_len;
								crc_q        <= ccfb_pkg::CRC_INIT;
								run_cnt_q    <= 8'd0;
								idx_q        <= 3'd0;
								state_q      <= F_HDR;
							end
						end else if (frame_open_q) begin
							state_q <= F_PAY;
						end
					end
				end
				F_HDR: begin
					if (go) begin
						crc_q <= ccfb_pkg::crc_byte(crc_q, cur_byte);
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd5) begin
							state_q <= (len_q == 8'd0) ? F_CRC0 : F_IDLE;
						end
					end
				end
				F_PAY: begin
					if (go) begin
						crc_q       <= ccfb_pkg::crc_byte(crc_q, cur_byte);
						bytes_rem_q <= rem_after;
						state_q     <= finishing ? F_CRC0 : F_IDLE;
					end
				end
				F_CRC0: begin
					if (go) begin
						state_q <= F_CRC1;
					end
				end
				F_CRC1: begin
					if (go) begin
						state_q <= F_FIN;
					end
				end
				F_FIN: begin
					if (go) begin
						run_cnt_q <= 8'd0;
						state_q   <= F_DELIM;
					end
				end
				F_DELIM: begin
					if (go) begin
						frame_open_q <= 1'b0;
						bytes_rem_q  <= 8'd0;
						crc_q        <= ccfb_pkg::CRC_INIT;
						run_cnt_q    <= 8'd0;
						state_q      <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/ccfb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccfb_back: output side of the frame builder
// Takes commands from the queue, sends the code byte of each block and then
// its buffered bytes out of the run buffer, or the delimiter, through a
// registered output stage.
// ----------------------------------------------------------------------------
module ccfb_back #(
	parameter int RUN_DEPTH = ccfb_pkg::RUN_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_not_empty,
	input  ccfb_pkg::cmd_t               cmd_head,
	output logic                         cmd_pop,
	output logic                         ram_rd_en,
	output logic [$clog2(RUN_DEPTH)-1:0] ram_rd_addr,
	input  logic [7:0]                   ram_rd_data,
	output logic                         slot_release,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [7:0]                   out_byte,
	output logic                         last_in_run,
	output logic                         frame_end
);

	localparam int PW = $clog2(RUN_DEPTH);

	typedef enum logic {B_IDLE, B_DATA} bstate_t;

	bstate_t       state_q;
	logic [7:0]    rem_q;
	logic          last_q;
	logic [PW-1:0] rd_ptr_q;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          last_in_run_q;
	logic          frame_end_q;
	logic          slot_free;
	logic          data_load;
	logic [PW-1:0] rd_ptr_inc;

	assign slot_free    = !out_valid_q || out_ready;
	assign cmd_pop      = (state_q == B_IDLE) && cmd_not_empty && slot_free;
	assign data_load    = (state_q == B_DATA) && slot_free;
	assign slot_release = data_load;
	assign rd_ptr_inc   = (rd_ptr_q == PW'(RUN_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;

	// A read is issued when a block with data starts and after each data byte
	// that still has a successor, so bytes leave one per cycle unless stalled.
	assign ram_rd_en = (cmd_pop && !cmd_head.is_delim && (cmd_head.count != 8'd0)) ||
	                   (data_load && (rem_q != 8'd1));
	assign ram_rd_addr = rd_ptr_q;

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_in_run = last_in_run_q;
	assign frame_end   = frame_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= B_IDLE;
			rem_q         <= 8'd0;
			last_q        <= 1'b0;
			rd_ptr_q      <= '0;
			out_valid_q   <= 1'b0;
			out_byte_q    <= 8'h00;
			last_in_run_q <= 1'b0;
			frame_end_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (ram_rd_en) begin
				rd_ptr_q <= rd_ptr_inc;
			end
			case (state_q)
				B_IDLE: begin
					if (cmd_pop) begin
						out_valid_q <= 1'b1;
						if (cmd_head.is_delim) begin
							out_byte_q    <= ccfb_pkg::DELIM;
							last_in_run_q <= cmd_head.last;
							frame_end_q   <= 1'b1;
						end else begin
							out_byte_q    <= cmd_head.count + 8'd1;
							last_in_run_q <= cmd_head.last && (cmd_head.count == 8'd0);
							frame_end_q   <= 1'b0;
							rem_q         <= cmd_head.count;
							last_q        <= cmd_head.last;
							if (cmd_head.count != 8'd0) begin
								state_q <= B_DATA;
							end
						end
					end
				end
				B_DATA: begin
					if (data_load) begin
						out_valid_q   <= 1'b1;
						out_byte_q    <= ram_rd_data;
						last_in_run_q <= last_q && (rem_q == 8'd1);
						frame_end_q   <= 1'b0;
						rem_q         <= rem_q - 8'd1;
						if (rem_q == 8'd1) begin
							state_q <= B_IDLE;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/cobs_crc_frame_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cobs_crc_frame_builder: COBS-encoded telemetry frames with CRC-16
// A header word opens a frame; payload words supply its bytes. The encoded
// frame leaves as a stream of bytes ending in a 0x00 delimiter.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) takes one word at a time. A header
// word (opcode 0) carries msg_id and msg_len; payload words (opcode 1) carry
// data_byte. Headers announcing more than the maximum payload, headers while
// a frame is open and payload words with no open frame are consumed silently.
// The output channel (out_valid/out_ready) moves one encoded byte per word,
// flagged last_in_run on the final byte caused by an input word and
// frame_end on the delimiter.
// Throughput is set by the front end, which walks the frame body one byte
// per cycle unless stalled; it takes a new word only when idle again,
// after the last word's bytes and, ending a frame, the CRC and close. The
// back end sends one byte per cycle from the run buffer unless stalled;
// a block's code byte is registered after the zero byte closing it is queued.
// When the receiver stalls, the back end holds its output register and the
// command queue and run buffer fill; the front end stalls once either is
// full, keeping in_ready low until it can go on. No bytes are lost.
// Reset clears all control state: no frame is open, the CRC is preset and
// both queues are empty. The run buffer needs no clearing pass.
// ----------------------------------------------------------------------------
module cobs_crc_frame_builder #(
	parameter int RUN_DEPTH = ccfb_pkg::RUN_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [31:0] msg_id,
	input  logic [7:0]  msg_len,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last_in_run,
	output logic        frame_end
);

	localparam int PW = $clog2(RUN_DEPTH);

	// Run buffer: a circular byte store shared by front and back end. The
	// front end writes nonzero body bytes in order; the back end reads them
	// back block by block, freeing each slot when its byte is registered.
	logic          ram_wr_en;
	logic [PW-1:0] ram_wr_addr;
	logic [7:0]    ram_wr_data;
	logic          ram_rd_en;
	logic [PW-1:0] ram_rd_addr;
	logic [7:0]    ram_rd_data;
	logic          slot_release;

	// Command queue handshake.
	logic           cmd_push;
	ccfb_pkg::cmd_t cmd_in;
	logic           cmd_not_full;
	logic           cmd_pop;
	logic           cmd_not_empty;
	ccfb_pkg::cmd_t cmd_head;

	ccfb_front #(
		.RUN_DEPTH(RUN_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.msg_id       (msg_id),
		.msg_len      (msg_len),
		.data_byte    (data_byte),
		.ram_wr_en    (ram_wr_en),
		.ram_wr_addr  (ram_wr_addr),
		.ram_wr_data  (ram_wr_data),
		.slot_release (slot_release),
		.cmd_push     (cmd_push),
		.cmd_out      (cmd_in),
		.cmd_not_full (cmd_not_full)
	);

	ccfb_ram #(
		.WIDTH(8),
		.DEPTH(RUN_DEPTH)
	) u_run_buf (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	ccfb_cmdq u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_cmd  (cmd_in),
		.not_full  (cmd_not_full),
		.pop       (cmd_pop),
		.not_empty (cmd_not_empty),
		.head_cmd  (cmd_head)
	);

	ccfb_back #(
		.RUN_DEPTH(RUN_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_not_empty (cmd_not_empty),
		.cmd_head      (cmd_head),
		.cmd_pop       (cmd_pop),
		.ram_rd_en     (ram_rd_en),
		.ram_rd_addr   (ram_rd_addr),
		.ram_rd_data   (ram_rd_data),
		.slot_release  (slot_release),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.last_in_run   (last_in_run),
		.frame_end     (frame_end)
	);

endmodule
